/* hdl/three_axis_pid_position_controller_macros.svh */
// Assertion macros for the three-axis PID position controller.
// Included by the top level; no other dependencies.
`ifndef THREE_AXIS_PID_POSITION_CONTROLLER_MACROS_SVH
`define THREE_AXIS_PID_POSITION_CONTROLLER_MACROS_SVH

`ifndef SYNTH
// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define TAPC_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define TAPC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define TAPC_ASSERT_SAME(label, ante, cons, msg)
`define TAPC_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

/* hdl/tapc_pkg.sv */
// Shared widths and types for the three-axis PID position controller.
// No dependencies; imported by the multiplier and the top level.
`default_nettype none

package tapc_pkg;

  localparam int AXES      = 3;
  localparam int FRAC_BITS = 16;
  localparam int AXIS_W    = (AXES > 1) ? $clog2(AXES) : 1;

  localparam int DATA_W = 32;
  localparam int OP_W   = DATA_W + 1;
  localparam int PROD_W = 2 * OP_W;

  localparam int IN_W  = 2 * AXES * DATA_W;
  localparam int OUT_W = AXES * DATA_W;

  typedef logic signed [OP_W-1:0]   op_t;
  typedef logic signed [PROD_W-1:0] prod_t;

endpackage

`default_nettype wire

/* hdl/tapc_mul.sv */
// Shared signed multiplier with a registered product.
// Depends on tapc_pkg for operand and product types.
`default_nettype none

module tapc_mul import tapc_pkg::*; (
  input  logic  clk,
  input  op_t   op_a,
  input  op_t   op_b,
  output prod_t prod_r
);

  always_ff @(posedge clk) begin
    prod_r <= op_a * op_b;
  end

endmodule

`default_nettype wire

/* hdl/three_axis_pid_position_controller.sv */
// Three-axis PID position controller: input word -> one velocity word.
//
// Channels: in_* carries one word of target and measured coordinates
// (signed Q16.16); out_* returns one word of three velocity commands.
// cfg_* writes the gain, clamp, period and rate registers (always ready);
// writes must be made only while the block is idle (not enforced by it).
// One 33x33 multiplier is shared by all products under a sequencer.
// Each axis passes through the error step, five multiplies and the final
// sum; after the last axis the result is handed to the output register.
// out_tvalid rises and in_tready returns at the same time, so a new input
// word is taken only once the previous one has been fully processed.
// A finished result waits in the output register while the next word is
// taken and processed; if the receiver is still stalling when that next
// result is done, the sequencer holds it until the output register frees.
// Reset (rst_n low, synchronous) clears the integral and previous error
// of every axis and loads the register defaults.
// Depends on tapc_pkg, tapc_mul and the assertion macro header.
`default_nettype none
`include "three_axis_pid_position_controller_macros.svh"

module three_axis_pid_position_controller import tapc_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  // target_x, target_y, target_z, measured_x, measured_y, measured_z
  input  logic [IN_W-1:0]  in_tdata,
  input  logic             in_tvalid,
  output logic             in_tready,
  // velocity_x, velocity_y, velocity_z
  output logic [OUT_W-1:0] out_tdata,
  output logic             out_tvalid,
  input  logic             out_tready,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [2:0]       cfg_index,
  input  logic [31:0]      cfg_data
);

  localparam logic [2:0] REG_KP     = 3'd0;
  localparam logic [2:0] REG_KI     = 3'd1;
  localparam logic [2:0] REG_KD     = 3'd2;
  localparam logic [2:0] REG_LIMIT  = 3'd3;
  localparam logic [2:0] REG_PERIOD = 3'd4;
  localparam logic [2:0] REG_RATE   = 3'd5;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_ERR  = 4'd1;
  localparam logic [3:0] ST_MDT  = 4'd2;
  localparam logic [3:0] ST_MRT  = 4'd3;
  localparam logic [3:0] ST_MKP  = 4'd4;
  localparam logic [3:0] ST_MKI  = 4'd5;
  localparam logic [3:0] ST_MKD  = 4'd6;
  localparam logic [3:0] ST_SUM  = 4'd7;
  localparam logic [3:0] ST_DONE = 4'd8;

  localparam int SH_W  = PROD_W - FRAC_BITS;
  localparam int ACC_W = SH_W + 2;
  localparam logic [AXIS_W-1:0] LAST_AXIS = AXIS_W'(AXES - 1);

  localparam logic signed [DATA_W-1:0] S_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] S_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  function automatic logic signed [DATA_W-1:0] sat_acc(input logic signed [ACC_W-1:0] v);
    logic [ACC_W-DATA_W:0] hi;
    hi = v[ACC_W-1:DATA_W-1];
    if (hi == '0 || hi == '1) begin
      return v[DATA_W-1:0];
    end else if (v[ACC_W-1]) begin
      return S_MIN;
    end else begin
      return S_MAX;
    end
  endfunction

  // Configuration registers.
  logic [31:0] kp_r, ki_r, kd_r;
  logic [30:0] lim_r;
  logic [15:0] dt_r;
  logic [30:0] rate_r;

  // Sequencer and per-item working registers.
  logic [3:0]               state_r, state_nxt;
  logic [AXIS_W-1:0]        axis_r;
  logic signed [DATA_W-1:0] tgt_r  [AXES];
  logic signed [DATA_W-1:0] meas_r [AXES];
  logic signed [DATA_W-1:0] prev_r [AXES];
  logic signed [DATA_W-1:0] integ_r[AXES];
  logic signed [DATA_W-1:0] vel_r  [AXES];
  logic signed [DATA_W-1:0] e_r, i_r, d_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic [OUT_W-1:0]         out_tdata_r;
  logic                     out_tvalid_r;

  op_t   op_a, op_b;
  prod_t prod_r;

  logic signed [DATA_W:0]   diff_in;
  logic signed [DATA_W-1:0] err_sat;
  logic signed [SH_W-1:0]   sh_term;
  logic signed [ACC_W-1:0]  term_ext;
  logic signed [ACC_W-1:0]  isum;
  logic signed [ACC_W-1:0]  lim_ext;
  logic signed [DATA_W-1:0] i_new;
  logic                     in_acc;
  logic                     out_free;

  assign in_tready  = (state_r == ST_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign cfg_ready  = 1'b1;
  assign out_tdata  = out_tdata_r;
  assign out_tvalid = out_tvalid_r;
  assign out_free   = !out_tvalid_r || out_tready;

  // Error with saturation to 32 bits.
  assign diff_in = {tgt_r[axis_r][DATA_W-1], tgt_r[axis_r]}
                 - {meas_r[axis_r][DATA_W-1], meas_r[axis_r]};
  always_comb begin
    if (diff_in[DATA_W] != diff_in[DATA_W-1]) begin
      err_sat = diff_in[DATA_W] ? S_MIN : S_MAX;
    end else begin
      err_sat = diff_in[DATA_W-1:0];
    end
  end

  // Arithmetic shift right by the fraction width rounds toward minus infinity.
  assign sh_term  = prod_r[PROD_W-1:FRAC_BITS];
  assign term_ext = ACC_W'(sh_term);

  // Integral step and clamp to the configured magnitude.
  assign isum    = ACC_W'(integ_r[axis_r]) + term_ext;
  assign lim_ext = {{(ACC_W-31){1'b0}}, lim_r};
  always_comb begin
    if (isum > lim_ext) begin
      i_new = lim_ext[DATA_W-1:0];
    end else if (isum < -lim_ext) begin
      i_new = DATA_W'(-lim_ext);
    end else begin
      i_new = isum[DATA_W-1:0];
    end
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    unique case (state_r)
      ST_MDT: begin
        op_a = OP_W'(e_r);
        op_b = {{(OP_W-16){1'b0}}, dt_r};
      end
      ST_MRT: begin
        op_a = OP_W'(e_r) - OP_W'(prev_r[axis_r]);
        op_b = {{(OP_W-31){1'b0}}, rate_r};
      end
      ST_MKP: begin
        op_a = OP_W'(e_r);
        op_b = {1'b0, kp_r};
      end
      ST_MKI: begin
        op_a = OP_W'(i_r);
        op_b = {1'b0, ki_r};
      end
      ST_MKD: begin
        op_a = OP_W'(d_r);
        op_b = {1'b0, kd_r};
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  tapc_mul u_mul (
    .clk    (clk),
    .op_a   (op_a),
    .op_b   (op_b),
    .prod_r (prod_r)
  );

  always_comb begin
    unique case (state_r)
      ST_IDLE: state_nxt = in_acc ? ST_ERR : ST_IDLE;
      ST_ERR:  state_nxt = ST_MDT;
      ST_MDT:  state_nxt = ST_MRT;
      ST_MRT:  state_nxt = ST_MKP;
      ST_MKP:  state_nxt = ST_MKI;
      ST_MKI:  state_nxt = ST_MKD;
      ST_MKD:  state_nxt = ST_SUM;
      ST_SUM:  state_nxt = (axis_r == LAST_AXIS) ? ST_DONE : ST_ERR;
      ST_DONE: state_nxt = out_free ? ST_IDLE : ST_DONE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control state, configuration and the per-axis stores.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      axis_r       <= '0;
      out_tvalid_r <= 1'b0;
      kp_r         <= '0;
      ki_r         <= '0;
      kd_r         <= '0;
      lim_r        <= 31'd655360;
      dt_r         <= 16'd1311;
      rate_r       <= 31'd3276800;
      for (int k = 0; k < AXES; k++) begin
        prev_r[k]  <= '0;
        integ_r[k] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_KP:     kp_r   <= cfg_data;
          REG_KI:     ki_r   <= cfg_data;
          REG_KD:     kd_r   <= cfg_data;
          REG_LIMIT:  lim_r  <= cfg_data[30:0];
          REG_PERIOD: dt_r   <= cfg_data[15:0];
          REG_RATE:   rate_r <= cfg_data[30:0];
          default: ;
        endcase
      end
      if (in_acc) begin
        axis_r <= '0;
      end else if (state_r == ST_SUM) begin
        axis_r <= (axis_r == LAST_AXIS) ? '0 : axis_r + AXIS_W'(1);
      end
      if (state_r == ST_MRT) begin
        integ_r[axis_r] <= i_new;
      end
      if (state_r == ST_SUM) begin
        prev_r[axis_r] <= e_r;
      end
      if (state_r == ST_DONE && out_free) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      for (int k = 0; k < AXES; k++) begin
        tgt_r[k]  <= in_tdata[k*DATA_W +: DATA_W];
        meas_r[k] <= in_tdata[(AXES+k)*DATA_W +: DATA_W];
      end
    end
    unique case (state_r)
      ST_ERR: e_r   <= err_sat;
      ST_MRT: i_r   <= i_new;
      ST_MKP: d_r   <= sat_acc(term_ext);
      ST_MKI: acc_r <= term_ext;
      ST_MKD: acc_r <= acc_r + term_ext;
      ST_SUM: vel_r[axis_r] <= sat_acc(acc_r + term_ext);
      default: ;
    endcase
    if (state_r == ST_DONE && out_free) begin
      for (int k = 0; k < AXES; k++) begin
        out_tdata_r[k*DATA_W +: DATA_W] <= vel_r[k];
      end
    end
  end

  `TAPC_ASSERT_SAME(a_integral_in_limit, state_r == ST_MKI, (i_r <= $signed({1'b0, lim_r})) && (i_r >= -$signed({1'b0, lim_r})), "integral outside clamp")
  `TAPC_ASSERT_NEXT(a_accept_starts_axis0, in_tvalid && in_tready, state_r == ST_ERR && axis_r == '0, "accepted word did not start at first axis")
  `TAPC_ASSERT_NEXT(a_last_axis_done, state_r == ST_SUM && axis_r == LAST_AXIS, state_r == ST_DONE, "last axis did not finish the word")

endmodule

`default_nettype wire

/* bench/pid_velocity_checker.sv */
// Register index codes shared by the bench, and the checker for the PID controller.
// The checker watches the cfg, in and out channels and predicts each velocity word.
// Depends on tapc_pkg for widths and the axis count.
package pid_bench_pkg;

  typedef enum logic [2:0] {
    REG_KP_GAIN   = 3'd0,
    REG_KI_GAIN   = 3'd1,
    REG_KD_GAIN   = 3'd2,
    REG_INT_LIMIT = 3'd3,
    REG_PERIOD    = 3'd4,
    REG_RATE      = 3'd5,
    REG_SPARE_A   = 3'd6,
    REG_SPARE_B   = 3'd7
  } reg_index_t;

  localparam int NUM_REGS = 6;

endpackage

module pid_velocity_checker import tapc_pkg::*; import pid_bench_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [IN_W-1:0]  in_tdata,
  input  logic             in_tvalid,
  input  logic             in_tready,
  input  logic [OUT_W-1:0] out_tdata,
  input  logic             out_tvalid,
  input  logic             out_tready,
  input  logic             cfg_valid,
  input  logic             cfg_ready,
  input  logic [2:0]       cfg_index,
  input  logic [31:0]      cfg_data,
  output int               mismatches,
  output int               outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [OUT_W-1:0] velocity_word_t;

  logic [31:0] kp_gain;
  logic [31:0] ki_gain;
  logic [31:0] kd_gain;
  logic [30:0] int_limit;
  logic [15:0] period;
  logic [30:0] rate;

  longint last_error [AXES];
  longint integral [AXES];

  velocity_word_t velocity_q [$];

  function automatic longint clip32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  always @(posedge clk) begin : watch
    longint err;
    longint acc;
    longint der;
    longint vel;
    velocity_word_t want;
    velocity_word_t got;
    if (!rst_n) begin
      kp_gain   = '0;
      ki_gain   = '0;
      kd_gain   = '0;
      int_limit = 31'd655360;
      period    = 16'd1311;
      rate      = 31'd3276800;
      for (int a = 0; a < AXES; a++) begin
        last_error[a] = 0;
        integral[a]   = 0;
      end
      velocity_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_KP_GAIN:   kp_gain   = cfg_data;
          REG_KI_GAIN:   ki_gain   = cfg_data;
          REG_KD_GAIN:   kd_gain   = cfg_data;
          REG_INT_LIMIT: int_limit = cfg_data[30:0];
          REG_PERIOD:    period    = cfg_data[15:0];
          REG_RATE:      rate      = cfg_data[30:0];
          default: ;
        endcase
      end

      if (out_tvalid && out_tready) begin
        got = out_tdata;
        if (velocity_q.size() == 0) begin
          mismatches++;
          $display("%0t: velocity word %h arrived with nothing expected", $time, got);
        end else begin
          want = velocity_q.pop_front();
          for (int a = 0; a < AXES; a++) begin
            if (got[a*DATA_W +: DATA_W] !== want[a*DATA_W +: DATA_W]) begin
              mismatches++;
              $display("%0t: axis %0d velocity expected %0d, got %0d", $time, a,
                       $signed(want[a*DATA_W +: DATA_W]), $signed(got[a*DATA_W +: DATA_W]));
            end
          end
        end
      end

      // Arithmetic shifts of signed 64-bit products round toward minus infinity.
      if (in_tvalid && in_tready) begin
        for (int a = 0; a < AXES; a++) begin
          err = clip32(longint'($signed(in_tdata[a*DATA_W +: DATA_W]))
                     - longint'($signed(in_tdata[(AXES+a)*DATA_W +: DATA_W])));
          acc = integral[a] + ((err * longint'(period)) >>> FRAC_BITS);
          if (acc > longint'(int_limit)) acc = longint'(int_limit);
          if (acc < -longint'(int_limit)) acc = -longint'(int_limit);
          der = clip32(((err - last_error[a]) * longint'(rate)) >>> FRAC_BITS);
          vel = clip32(((longint'(kp_gain) * err) >>> FRAC_BITS)
                     + ((longint'(ki_gain) * acc) >>> FRAC_BITS)
                     + ((longint'(kd_gain) * der) >>> FRAC_BITS));
          integral[a]   = acc;
          last_error[a] = err;
          want[a*DATA_W +: DATA_W] = vel[31:0];
        end
        velocity_q.push_back(want);
      end
    end
    outstanding = velocity_q.size();
  end

endmodule

/* bench/tb_top.sv */
// Top of the PID controller bench: clock, reset, stimulus on all three channels
// and the verdict. Depends on tapc_pkg, the controller RTL and pid_velocity_checker.
module tb_top import tapc_pkg::*; import pid_bench_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PHASES       = 10;
  localparam int PHASE_WORDS  = 173;
  localparam int QUIET_PHASES = 2;

  typedef enum {
    STYLE_MODEST,
    STYLE_RANDOM,
    STYLE_ALL_ONES,
    STYLE_ZERO,
    STYLE_MIXED
  } gain_style_t;

  logic             clk;
  logic             rst_n;
  logic [IN_W-1:0]  in_tdata;
  logic             in_tvalid;
  logic             in_tready;
  logic [OUT_W-1:0] out_tdata;
  logic             out_tvalid;
  logic             out_tready;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [2:0]       cfg_index;
  logic [31:0]      cfg_data;
  int               mismatches;
  int               outstanding;
  bit               send_idle;
  bit               recv_idle;

  logic [31:0] target_pt [AXES];
  logic [31:0] measured_pt [AXES];
  logic [31:0] goal [AXES];
  logic [31:0] pos [AXES];

  three_axis_pid_position_controller uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  pid_velocity_checker u_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tdata    (in_tdata),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .out_tdata   (out_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  initial begin
    #10_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  // Receiver: stalls come in bursts while recv_idle is set.
  initial begin : receiver
    int hold;
    hold = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold == 0 && recv_idle && $urandom_range(0, 9) == 0) hold = $urandom_range(1, 15);
      if (hold > 0) begin
        out_tready = 1'b0;
        hold--;
      end else begin
        out_tready = 1'b1;
      end
    end
  end

  task automatic write_reg(input reg_index_t idx, input logic [31:0] value);
    cfg_index = idx;
    cfg_data  = value;
    cfg_valid = 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Returns once every velocity word owed by the block has been taken.
  task automatic settle();
    in_tvalid = 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic send_point();
    logic [IN_W-1:0] w;
    if (send_idle && $urandom_range(0, 5) == 0) begin
      in_tvalid = 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end
    for (int a = 0; a < AXES; a++) begin
      w[a*DATA_W +: DATA_W]        = target_pt[a];
      w[(AXES+a)*DATA_W +: DATA_W] = measured_pt[a];
    end
    in_tdata  = w;
    in_tvalid = 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic directed(input logic [31:0] tx, input logic [31:0] ty, input logic [31:0] tz,
                          input logic [31:0] mx, input logic [31:0] my, input logic [31:0] mz);
    target_pt[0]   = tx;
    target_pt[1]   = ty;
    target_pt[2]   = tz;
    measured_pt[0] = mx;
    measured_pt[1] = my;
    measured_pt[2] = mz;
    send_point();
  endtask

  function automatic logic [31:0] small_coord();
    logic [31:0] r;
    r = $urandom();
    return {{12{r[19]}}, r[19:0]};
  endfunction

  function automatic logic [31:0] rand_coord();
    logic [31:0] r;
    r = $urandom();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return small_coord();
      4, 5, 6, 7: return r;
      8:          return r[0] ? 32'h7FFF_FFFF : 32'h8000_0000;
      default:    return r[0] ? 32'hFFFF_FFFF : 32'h0000_0000;
    endcase
  endfunction

  function automatic logic [31:0] reg_value(input gain_style_t style);
    logic [31:0] r;
    r = $urandom();
    case (style)
      STYLE_MODEST:   return r >> $urandom_range(13, 24);
      STYLE_RANDOM:   return r;
      STYLE_ALL_ONES: return 32'hFFFF_FFFF;
      STYLE_ZERO:     return 32'h0000_0000;
      default: begin
        case ($urandom_range(0, 2))
          0:       return 32'h0000_0000;
          1:       return 32'hFFFF_FFFF;
          default: return r >> $urandom_range(0, 20);
        endcase
      end
    endcase
  endfunction

  // Mostly a measured point closing in on a slowly moving goal, so the
  // integral builds up and clamps; the rest is unrelated noise.
  task automatic random_point();
    logic [31:0] r;
    if ($urandom_range(0, 2) != 0) begin
      for (int a = 0; a < AXES; a++) begin
        r = $urandom();
        if ($urandom_range(0, 24) == 0) goal[a] = small_coord();
        pos[a] = pos[a] + 32'($signed(goal[a] - pos[a]) >>> 3) + {{22{r[9]}}, r[9:0]};
        target_pt[a]   = goal[a];
        measured_pt[a] = pos[a];
      end
    end else begin
      for (int a = 0; a < AXES; a++) begin
        target_pt[a]   = rand_coord();
        measured_pt[a] = rand_coord();
      end
    end
  endtask

  initial begin : stimulus
    gain_style_t style;
    rst_n     = 1'b0;
    in_tdata  = '0;
    in_tvalid = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = REG_KP_GAIN;
    cfg_data  = '0;
    send_idle = 1'b1;
    recv_idle = 1'b1;
    for (int a = 0; a < AXES; a++) begin
      goal[a] = '0;
      pos[a]  = '0;
    end
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed words: gains set, the other registers at their reset values.
    write_reg(REG_KP_GAIN, 32'h0001_8000);
    write_reg(REG_KI_GAIN, 32'h0000_8000);
    write_reg(REG_KD_GAIN, 32'h0000_1000);
    // Writes past the last register must leave everything unchanged.
    write_reg(REG_SPARE_A, 32'hFFFF_FFFF);
    write_reg(REG_SPARE_B, 32'h1234_5678);
    directed(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
    directed(32'h7FFF_FFFF, 32'h8000_0000, 32'h1, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0);
    directed(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0);
    directed(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
             32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    directed(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h0, 32'h0, 32'h0);
    directed(32'h0, 32'h0, 32'h0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    directed(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0);
    directed(32'h1, 32'h1, 32'h1, 32'h0, 32'h0, 32'h0);

    // A tight clamp with a long period drives the integral into both limits.
    settle();
    write_reg(REG_INT_LIMIT, 32'h0000_0100);
    write_reg(REG_PERIOD, 32'h0000_FFFF);
    repeat (4) directed(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h0, 32'h0, 32'h0);
    repeat (4) directed(32'h0, 32'h0, 32'h0, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000);

    settle();
    write_reg(REG_PERIOD, 32'h0);
    write_reg(REG_RATE, 32'h0);
    directed(32'h0003_0000, 32'hFFFD_0000, 32'h7FFF_FFFF, 32'h0, 32'h0, 32'h8000_0000);
    directed(32'h0, 32'h0, 32'h0, 32'h0003_0000, 32'hFFFD_0000, 32'h0);

    // All-ones gains and limits push every term and the sum into saturation.
    settle();
    for (int r = 0; r < NUM_REGS; r++) write_reg(reg_index_t'(r), 32'hFFFF_FFFF);
    directed(32'h7FFF_FFFF, 32'h8000_0000, 32'h1, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0);
    directed(32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h1);
    directed(32'h1, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);

    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      if (ph < 5) style = gain_style_t'(ph);
      else style = (ph % 2 != 0) ? STYLE_RANDOM : STYLE_MODEST;
      for (int r = 0; r < NUM_REGS; r++) write_reg(reg_index_t'(r), reg_value(style));
      send_idle = (ph < PHASES - QUIET_PHASES) && ($urandom_range(0, 3) != 0);
      recv_idle = (ph < PHASES - QUIET_PHASES) && ($urandom_range(0, 3) != 0);
      for (int n = 0; n < PHASE_WORDS; n++) begin
        random_point();
        send_point();
      end
    end

    settle();
    repeat (30) @(negedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
